// ===== rtl/move_to_front_active_set_encoder_unit_macros.svh =====
// Assertion macros used by the move-to-front encoder unit RTL.
`ifndef MOVE_TO_FRONT_ACTIVE_SET_ENCODER_UNIT_MACROS_SVH
`define MOVE_TO_FRONT_ACTIVE_SET_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define MTFASE_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that a condition never holds at a rising clock edge outside reset.
`define MTFASE_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MTFASE_ASSERT(name, clk, rst_n, prop)
`define MTFASE_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== rtl/mtfase_pkg.sv =====
// Shared types and constants of the move-to-front encoder.
package mtfase_pkg;

	localparam int KIND_W = 2;
	localparam int SYM_W  = 8;
	localparam int POS_W  = 6;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd2;

	// Per-cycle controls broadcast to every cell of the list
	typedef struct packed {
		logic append;    // write the request symbol into the tail cell
		logic compare;   // capture the match of each cell against the symbol
		logic shift_en;  // move the matched entry to the front
	} cell_ctrl_t;

endpackage

// ===== rtl/move_to_front_active_set_encoder_unit.sv =====
// Move-to-front encoder over a list of active symbols held in a chain of cells.
// Clear and append requests return no result.
// Encode compares in all cells in the request cycle, then moves to front once the result register is free.
// The result register loads at the end of the move cycle and holds until taken.
// Async reset empties the list, clears the overflow flag and the result; contents are not cleared.
module move_to_front_active_set_encoder_unit #(
	parameter int LIST_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mtfase_pkg::KIND_W-1:0] kind,
	input  logic [mtfase_pkg::SYM_W-1:0]  symbol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mtfase_pkg::POS_W-1:0]  position,
	output logic                          found,
	output logic                          overflow
);
	import mtfase_pkg::*;

`include "move_to_front_active_set_encoder_unit_macros.svh"

	localparam int LEN_W = $clog2(LIST_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_MOVE
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] len_q;
	logic             dropped_q;
	logic [SYM_W-1:0] sym_q;
	logic             out_valid_q;
	logic [POS_W-1:0] position_q;
	logic             found_q;
	logic             overflow_q;

	logic                  accept;
	logic                  not_full;
	logic                  move_go;
	cell_ctrl_t            ctrl;
	logic [SYM_W-1:0]      cell_data [LIST_DEPTH];
	logic [LIST_DEPTH:0]   seen;
	logic [LIST_DEPTH-1:0] first_hit;
	logic [POS_W-1:0]      pos_c;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign not_full = len_q < LEN_W'(LIST_DEPTH);
	// Move only when the result register is free
	assign move_go  = (state_q == S_MOVE) && (!out_valid_q || out_ready);

	assign ctrl.append   = accept && (kind == KIND_APPEND) && not_full;
	assign ctrl.compare  = accept && (kind == KIND_ENCODE);
	assign ctrl.shift_en = move_go;

	// Chain of cells; cell 0 takes the encoded symbol on a move
	assign seen[0] = 1'b0;
	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		logic [SYM_W-1:0] prev;
		if (g == 0) begin : g_head
			assign prev = sym_q;
		end else begin : g_body
			assign prev = cell_data[g-1];
		end
		mtfase_cell #(
			.LEN_W(LEN_W),
			.INDEX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.symbol    (symbol),
			.length    (len_q),
			.prev_data (prev),
			.seen_in   (seen[g]),
			.hit_any   (seen[LIST_DEPTH]),
			.data      (cell_data[g]),
			.seen_out  (seen[g+1]),
			.first_hit (first_hit[g])
		);
	end

	// Encode the first matching place, low bits only
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (first_hit[i]) begin
				pos_c = pos_c | POS_W'(i);
			end
		end
	end

	// Control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			dropped_q   <= 1'b0;
			sym_q       <= '0;
			out_valid_q <= 1'b0;
			position_q  <= '0;
			found_q     <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			// Drop the taken result unless a new one loads in the same cycle
			if (out_valid_q && out_ready && !move_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_CLEAR: begin
								len_q     <= '0;
								dropped_q <= 1'b0;
							end
							KIND_APPEND: begin
								if (not_full) begin
									len_q <= len_q + LEN_W'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							KIND_ENCODE: begin
								sym_q   <= symbol;
								state_q <= S_MOVE;
							end
							default: begin
							end
						endcase
					end
				end
				S_MOVE: begin
					if (move_go) begin
						out_valid_q <= 1'b1;
						position_q  <= pos_c;
						found_q     <= seen[LIST_DEPTH];
						overflow_q  <= dropped_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign found     = found_q;
	assign overflow  = overflow_q;

	`MTFASE_ASSERT(a_len_bound, clk, arst_n, len_q <= LEN_W'(LIST_DEPTH))
	`MTFASE_ASSERT(a_first_hit_unique, clk, arst_n, $onehot0(first_hit))
	`MTFASE_ASSERT(a_result_after_move, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_MOVE))
	`MTFASE_ASSERT_NEVER(a_no_accept_in_move, clk, arst_n, (state_q == S_MOVE) && in_ready)

endmodule

// ===== rtl/mtfase_cell.sv =====
// One list entry: holds a symbol, compares it and hands it to its neighbor on a move.
module mtfase_cell #(
	parameter int LEN_W = 7,
	parameter int INDEX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mtfase_pkg::cell_ctrl_t      ctrl,
	input  logic [mtfase_pkg::SYM_W-1:0] symbol,
	input  logic [LEN_W-1:0]            length,
	input  logic [mtfase_pkg::SYM_W-1:0] prev_data,
	input  logic                        seen_in,
	input  logic                        hit_any,
	output logic [mtfase_pkg::SYM_W-1:0] data,
	output logic                        seen_out,
	output logic                        first_hit
);
	import mtfase_pkg::*;

	logic [SYM_W-1:0] data_q;
	logic             match_q;
	logic             valid;
	logic             tail;
	logic             shift;

	// Entry is live below the list length; tail is the next free slot
	assign valid = LEN_W'(INDEX) < length;
	assign tail  = LEN_W'(INDEX) == length;
	// Shift when a hit exists at this place or behind it
	assign shift = ctrl.shift_en && hit_any && !seen_in;

	// Hold the stored symbol, load on append, take the neighbor on a move
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= prev_data;
		end else if (ctrl.append && tail) begin
			data_q <= symbol;
		end
	end

	// Capture the compare result in the request cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.compare) begin
			match_q <= valid && (data_q == symbol);
		end
	end

	assign data      = data_q;
	assign seen_out  = seen_in | match_q;
	assign first_hit = match_q & ~seen_in;

endmodule
